>>> rtl/linear_sieve_totient_mobius_top_assert.svh
// Assertion macros for the linear sieve block.
`ifndef LINEAR_SIEVE_TOTIENT_MOBIUS_TOP_ASSERT_SVH
`define LINEAR_SIEVE_TOTIENT_MOBIUS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge out of reset
`define LSIEVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen out of reset
`define LSIEVE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LSIEVE_ASSERT(lbl, prop, msg)
`define LSIEVE_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/lsieve_pkg.sv
// Shared types and constants of the linear sieve block.
`default_nettype none
package lsieve_pkg;
  localparam int MAX_N_DEF       = 65536;
  localparam int PRIME_DEPTH_DEF = 8192;
  localparam int VAL_W           = 16;
  // table word: {composite, moebius[1:0], totient[15:0]}
  localparam int WORD_W          = 19;
  localparam logic [1:0] MU_ZERO = 2'b00;
  localparam logic [1:0] MU_ONE  = 2'b01;
  localparam logic [1:0] MU_NEG  = 2'b11;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_I, S_GOT_I, S_K_CHK, S_P_RD, S_P_GOT,
    S_T_GOT, S_M_GOT, S_DIV, S_MUL, S_WR_M, S_REPORT
  } state_t;

  typedef struct packed {
    logic clr;
    logic take;
    logic got_i;
    logic k_inc;
    logic p_rd;
    logic p_got;
    logic t_got;
    logic m_got;
    logic mul;
    logic wr_m;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic adv_ok;
    logic k_end;
    logic stop;
    logic div_busy;
    logic rem_zero;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

>>> rtl/lsieve_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lsieve_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/lsieve_div.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
`default_nettype none
module lsieve_div
  import lsieve_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] dividend,
  input  wire logic [VAL_W-1:0] divisor,
  output logic                  busy,
  output logic      [VAL_W-1:0] rem
);
  localparam int CNT_W = $clog2(VAL_W + 1);

  logic [VAL_W-1:0] a_r, a_nxt, b_r, rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [VAL_W:0]   shifted;

  // one shift-subtract step
  always_comb begin
    shifted  = {rem_r, a_r[VAL_W-1]};
    a_nxt    = {a_r[VAL_W-2:0], 1'b0};
    if (shifted >= {1'b0, b_r}) begin
      rem_nxt = VAL_W'(shifted - {1'b0, b_r});
    end else begin
      rem_nxt = shifted[VAL_W-1:0];
    end
    cnt_nxt  = cnt_r + CNT_W'(1);
    busy_nxt = (cnt_nxt != CNT_W'(VAL_W));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= dividend;
      b_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      a_r   <= a_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

>>> rtl/lsieve_dp.sv
// Datapath: tables, prime list, counters, arithmetic and output register.
`default_nettype none
module lsieve_dp
  import lsieve_pkg::*;
#(
  parameter int MAX_N       = MAX_N_DEF,
  parameter int PRIME_DEPTH = PRIME_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  input  wire logic             cfg_wr_en,
  input  wire logic [VAL_W-1:0] cfg_wr_data,
  input  wire logic             in_advance,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic      [VAL_W-1:0] out_number,
  output logic      [VAL_W-1:0] out_totient,
  output logic signed [1:0]     out_moebius,
  output logic                  out_is_prime,
  output logic                  out_last
);
  localparam int AW = $clog2(MAX_N);
  localparam int PW = $clog2(PRIME_DEPTH);
  localparam int CW = $clog2(PRIME_DEPTH + 1);
  localparam logic [31:0] MAXV = 32'(MAX_N - 1);

  logic [VAL_W-1:0]  limit_r, cur_r, p_r, tot_p_r, tot_r;
  logic [WORD_W-1:0] cur_word_r, cur_word_nxt;
  logic [1:0]        old_mu_r;
  logic [31:0]       prod_r;
  logic [AW-1:0]     clr_r;
  logic [CW-1:0]     count_r, k_r;
  logic [VAL_W-1:0]  lim_eff, mul_b, div_rem;
  logic              div_busy, is_one, is_new_prime, push;
  logic              out_valid_r;

  // main table and prime list ports
  logic              t_we;
  logic [AW-1:0]     t_waddr, t_raddr;
  logic [WORD_W-1:0] t_wdata, t_rdata;
  logic [VAL_W-1:0]  p_rdata;

  // limit register and its clamp to the table size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end
  assign lim_eff = (32'(limit_r) > MAXV) ? MAXV[VAL_W-1:0] : limit_r;

  // classification of the current integer
  assign is_one       = (cur_r == 16'd1);
  assign is_new_prime = !is_one && !t_rdata[WORD_W-1];
  assign push         = cmd.got_i && is_new_prime && (count_r < CW'(PRIME_DEPTH));

  always_comb begin
    if (is_one) begin
      cur_word_nxt = {1'b0, MU_ONE, 16'd1};
    end else if (is_new_prime) begin
      cur_word_nxt = {1'b0, MU_NEG, cur_r - 16'd1};
    end else begin
      cur_word_nxt = t_rdata;
    end
  end

  // table write select
  always_comb begin
    t_we    = 1'b0;
    t_waddr = AW'(cur_r);
    t_wdata = cur_word_nxt;
    priority if (cmd.clr) begin
      t_we    = 1'b1;
      t_waddr = clr_r;
      t_wdata = '0;
    end else if (cmd.got_i) begin
      t_we    = is_one || is_new_prime;
    end else if (cmd.wr_m) begin
      t_we    = 1'b1;
      t_waddr = AW'(prod_r[VAL_W-1:0]);
      t_wdata = {1'b1, div_rem != '0 ? 2'(~cur_word_r[17:16] + 2'd1) : old_mu_r, tot_r};
    end
  end

  // table read select
  always_comb begin
    priority if (cmd.p_got) begin
      t_raddr = AW'(p_rdata);
    end else if (cmd.t_got) begin
      t_raddr = AW'(prod_r[VAL_W-1:0]);
    end else begin
      t_raddr = AW'(cur_r);
    end
  end

  lsieve_ram #(.WIDTH(WORD_W), .DEPTH(MAX_N)) u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  lsieve_ram #(.WIDTH(VAL_W), .DEPTH(PRIME_DEPTH)) u_primes (
    .clk   (clk),
    .we    (push),
    .waddr (count_r[PW-1:0]),
    .wdata (cur_r),
    .raddr (k_r[PW-1:0]),
    .rdata (p_rdata)
  );

  lsieve_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.t_got),
    .dividend (cur_r),
    .divisor  (p_r),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      cur_r      <= '0;
      count_r    <= '0;
      k_r        <= '0;
      cur_word_r <= '0;
    end else begin
      if (cmd.clr) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.take && sts.adv_ok) begin
        cur_r <= cur_r + 16'd1;
      end
      if (push) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.got_i) begin
        cur_word_r <= cur_word_nxt;
        k_r        <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + CW'(1);
      end
    end
  end

  // prime walk arithmetic
  assign mul_b = (div_rem != '0) ? tot_p_r : p_r;
  always_ff @(posedge clk) begin
    if (cmd.p_got) begin
      p_r    <= p_rdata;
      prod_r <= 32'(cur_r) * 32'(p_rdata);
    end
    if (cmd.t_got) begin
      tot_p_r <= t_rdata[VAL_W-1:0];
    end
    if (cmd.m_got) begin
      old_mu_r <= t_rdata[17:16];
    end
    if (cmd.mul) begin
      tot_r <= 16'(cur_word_r[VAL_W-1:0] * mul_b);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_number <= cur_r;
      out_last   <= (cur_r == limit_r);
      if (cur_r == '0) begin
        out_totient  <= '0;
        out_moebius  <= MU_ZERO;
        out_is_prime <= 1'b0;
      end else begin
        out_totient  <= cur_word_r[VAL_W-1:0];
        out_moebius  <= cur_word_r[17:16];
        out_is_prime <= (cur_r >= 16'd2) && !cur_word_r[WORD_W-1];
      end
    end
  end
  assign out_valid = out_valid_r;

  // status to the controller
  assign sts.clr_done = (clr_r == AW'(MAX_N - 1));
  assign sts.adv_ok   = in_advance && (cur_r < lim_eff);
  assign sts.k_end    = (k_r >= count_r);
  assign sts.stop     = (p_r < 16'd2) || (prod_r > {16'b0, lim_eff});
  assign sts.div_busy = div_busy;
  assign sts.rem_zero = (div_rem == '0);
  assign sts.out_free = !out_valid_r || out_ready;
endmodule
`default_nettype wire

>>> rtl/lsieve_ctrl.sv
// Controller: sequences the clearing pass, the prime walk and the report.
`default_nettype none
module lsieve_ctrl
  import lsieve_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = sts.adv_ok ? S_RD_I : S_REPORT;
      S_RD_I:   state_nxt = S_GOT_I;
      S_GOT_I:  state_nxt = S_K_CHK;
      S_K_CHK:  state_nxt = sts.k_end ? S_REPORT : S_P_RD;
      S_P_RD:   state_nxt = S_P_GOT;
      S_P_GOT:  state_nxt = S_T_GOT;
      S_T_GOT:  state_nxt = sts.stop ? S_REPORT : S_M_GOT;
      S_M_GOT:  state_nxt = S_DIV;
      S_DIV:    if (!sts.div_busy) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_WR_M;
      S_WR_M:   state_nxt = sts.rem_zero ? S_REPORT : S_K_CHK;
      S_REPORT: if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR:  cmd.clr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_RD_I:   ;
      S_GOT_I:  cmd.got_i = 1'b1;
      S_K_CHK:  ;
      S_P_RD:   cmd.p_rd = 1'b1;
      S_P_GOT:  cmd.p_got = 1'b1;
      S_T_GOT:  cmd.t_got = !sts.stop;
      S_M_GOT:  cmd.m_got = 1'b1;
      S_DIV:    ;
      S_MUL:    cmd.mul = 1'b1;
      S_WR_M: begin
        cmd.wr_m  = 1'b1;
        cmd.k_inc = !sts.rem_zero;
      end
      S_REPORT: cmd.load_out = sts.out_free;
      default:  ;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/linear_sieve_totient_mobius_top.sv
// Top level of the linear sieve: totient, Moebius value and primality per integer.
// After reset the block sweeps its number table once, one entry per cycle, before
// in_ready first rises; limit writes are taken throughout. An input transfer with
// advance low, or with the limit reached, goes from accept straight to report. An
// advance reads the integer's entry and walks the stored primes: for each it reads
// the prime and its entry, stops if the product passes the limit, reads the
// product's entry, waits on the remainder unit (one bit per cycle), multiplies and
// writes it; it stops on a zero remainder or at the list end, and visits about one
// prime per integer on average. One result waits in the output register while
// the next item is worked on; the report step holds while that register is full.
`default_nettype none
`include "linear_sieve_totient_mobius_top_assert.svh"
module linear_sieve_totient_mobius_top
  import lsieve_pkg::*;
#(
  parameter int MAX_N       = MAX_N_DEF,
  parameter int PRIME_DEPTH = PRIME_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [VAL_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_advance,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [VAL_W-1:0] out_number,
  output logic      [VAL_W-1:0] out_totient,
  output logic signed [1:0]     out_moebius,
  output logic                  out_is_prime,
  output logic                  out_last
);
  cmd_t cmd;
  sts_t sts;

  lsieve_dp #(.MAX_N(MAX_N), .PRIME_DEPTH(PRIME_DEPTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_advance   (in_advance),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_number   (out_number),
    .out_totient  (out_totient),
    .out_moebius  (out_moebius),
    .out_is_prime (out_is_prime),
    .out_last     (out_last)
  );

  lsieve_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // a transfer in makes the block busy for at least the next cycle
  `LSIEVE_ASSERT(a_busy_after_take, (in_valid && in_ready) |=> !in_ready, "ready after transfer")
  // a prime always carries Moebius -1
  `LSIEVE_ASSERT(a_prime_mu, (out_valid && out_is_prime) |-> (out_moebius == MU_NEG), "prime mu")
  // the result before the first advance has zero totient and is not prime
  `LSIEVE_NEVER(a_zero_result, out_valid && (out_number == '0) && (out_totient != '0 || out_is_prime), "zero result")
endmodule
`default_nettype wire

>>> test/linear_sieve_totient_mobius_top_tb.sv
// Self-checking testbench for the linear sieve totient/Moebius block.
`default_nettype none
module linear_sieve_totient_mobius_top_tb;
  import lsieve_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_MAX_N   = MAX_N_DEF;
  localparam int TB_PDEPTH  = PRIME_DEPTH_DEF;
  localparam int WATCHDOG   = 300000;
  localparam int DRAIN_WAIT = 200;

  typedef struct {
    logic [VAL_W-1:0] number;
    logic [VAL_W-1:0] totient;
    logic signed [1:0] moebius;
    logic is_prime;
    logic last;
  } sieve_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [VAL_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_advance = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [VAL_W-1:0] out_number;
  logic [VAL_W-1:0] out_totient;
  logic signed [1:0] out_moebius;
  logic out_is_prime;
  logic out_last;

  // shadow copy of the sieve state
  bit              marked[TB_MAX_N];
  int unsigned     primes[TB_PDEPTH];
  bit [31:0]       phi[TB_MAX_N];
  bit signed [1:0] mu[TB_MAX_N];
  int unsigned     num_primes = 0;
  int unsigned     walk_pos = 0;
  int unsigned     limit_reg = 65535;

  sieve_result_t pending_results[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  linear_sieve_totient_mobius_top uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_advance(in_advance),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_number(out_number), .out_totient(out_totient), .out_moebius(out_moebius),
    .out_is_prime(out_is_prime), .out_last(out_last)
  );

  // mark multiples of i and fill their totient and Moebius entries
  function automatic void sieve_integer(int unsigned i, int unsigned lim);
    int unsigned p;
    longint unsigned prod;
    if (i == 1) begin
      phi[1] = 1;
      mu[1] = 2'sd1;
      return;
    end
    if (!marked[i]) begin
      if (num_primes < TB_PDEPTH) begin
        primes[num_primes] = i;
        num_primes++;
      end
      phi[i] = i - 1;
      mu[i] = -2'sd1;
    end
    for (int unsigned k = 0; k < num_primes; k++) begin
      p = primes[k];
      prod = longint'(i) * longint'(p);
      if (p < 2 || prod > lim) break;
      marked[prod] = 1'b1;
      if (i % p != 0) begin
        phi[prod] = phi[i] * phi[p];
        mu[prod] = -mu[i];
      end else begin
        phi[prod] = phi[i] * p;
        break;
      end
    end
  endfunction

  // result of one accepted item
  function automatic sieve_result_t predict_sieve(bit adv);
    sieve_result_t r;
    int unsigned lim;
    lim = (limit_reg > TB_MAX_N - 1) ? TB_MAX_N - 1 : limit_reg;
    if (adv && walk_pos < lim) begin
      walk_pos++;
      sieve_integer(walk_pos, lim);
    end
    r.number = walk_pos[VAL_W-1:0];
    if (walk_pos == 0) begin
      r.totient = '0;
      r.moebius = 2'sd0;
      r.is_prime = 1'b0;
    end else begin
      r.totient = phi[walk_pos][VAL_W-1:0];
      r.moebius = mu[walk_pos];
      r.is_prime = (walk_pos >= 2) && !marked[walk_pos];
    end
    r.last = (walk_pos == limit_reg);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // one input transfer; returns right after the accepting edge
  task automatic send_item(bit adv);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_advance <= adv;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), predict_sieve(adv));
  endtask

  // write the limit once the block has drained
  task automatic write_limit(int unsigned value);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[VAL_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = value & 16'hFFFF;
  endtask

  // result checker
  always @(posedge clk) begin
    sieve_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, number", out_number, -1);
      end else begin
        e = pending_results.pop_front();
        if (out_number !== e.number) report_mismatch("number", out_number, e.number);
        if (out_totient !== e.totient) report_mismatch("totient", out_totient, e.totient);
        if (out_moebius !== e.moebius) report_mismatch("moebius", out_moebius, e.moebius);
        if (out_is_prime !== e.is_prime)
          report_mismatch("is_prime", out_is_prime, e.is_prime);
        if (out_last !== e.last) report_mismatch("last", out_last, e.last);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // before any advance, and with a zero limit
  task automatic test_before_first_advance();
    send_item(1'b0);
    write_limit(0);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  // limit of one: walk stops at 1
  task automatic test_limit_one();
    write_limit(1);
    send_item(1'b1);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  // short walk to a limit, then a limit below the current number, then reopen
  task automatic test_limit_changes();
    write_limit(65535);
    repeat (4) send_item(1'b1);
    send_item(1'b0);
    write_limit(12);
    repeat (9) send_item(1'b1);
    write_limit(5);
    send_item(1'b1);
    send_item(1'b0);
    write_limit(20);
    repeat (3) send_item(1'b1);
  endtask

  // random items under one idling mode, preceded by a random limit
  task automatic test_random_phase(int idle, int stall, int count);
    int unsigned sel;
    int unsigned new_lim;
    sel = $urandom_range(9);
    if (sel < 2) new_lim = 65535;
    else if (sel < 3) new_lim = $urandom_range(walk_pos);
    else new_lim = walk_pos + $urandom_range(count, 20);
    write_limit(new_lim);
    idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      send_item($urandom_range(99) < 85);
      // occasionally drop idling for the rest of the phase
      if ($urandom_range(99) == 0) idle_pct = 0;
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_before_first_advance();
    test_limit_one();
    test_limit_changes();
    test_random_phase(0, 0, 310);
    test_random_phase(80, 0, 310);
    test_random_phase(0, 80, 310);
    test_random_phase(34, 34, 310);
    write_limit(65535);

    // drain
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/lsieve_pkg.sv
rtl/lsieve_ram.sv
rtl/lsieve_div.sv
rtl/lsieve_dp.sv
rtl/lsieve_ctrl.sv
rtl/linear_sieve_totient_mobius_top.sv
test/linear_sieve_totient_mobius_top_tb.sv
